// File: rtl/core/adv_res_pkg.sv
// ----------------------------------------------------------------------------
// adv_res_pkg
// Shared types, constants and microcode tables of the advection residual core.
// ----------------------------------------------------------------------------
package adv_res_pkg;

    localparam int MAX_X      = 16;
    localparam int MAX_Y      = 16;
    localparam int MAX_Z      = 16;
    localparam int NUM_GRIDS  = 12;
    localparam int GRID_CELLS = MAX_X * MAX_Y * MAX_Z;
    localparam int DEPTH      = NUM_GRIDS * GRID_CELLS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CW         = 7;
    localparam int NUM_SLOTS  = 21;
    localparam int NUM_JOBS   = 20;
    localparam int NUM_PROG   = 25;
    localparam int ACC_W      = 52;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_COMPUTE = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    localparam logic [2:0] REG_SIZE_X = 3'd0;
    localparam logic [2:0] REG_SIZE_Y = 3'd1;
    localparam logic [2:0] REG_SIZE_Z = 3'd2;
    localparam logic [2:0] REG_WRAP   = 3'd3;
    localparam logic [2:0] REG_INV_DT = 3'd4;
    localparam logic [2:0] REG_INV_HX = 3'd5;
    localparam logic [2:0] REG_INV_HY = 3'd6;
    localparam logic [2:0] REG_INV_HZ = 3'd7;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;
    localparam logic [1:0] AX_T = 2'd3;

    localparam logic [2:0] PI_LOAD  = 3'd0;
    localparam logic [2:0] PI_ADD   = 3'd1;
    localparam logic [2:0] PI_MAC   = 3'd2;
    localparam logic [2:0] PI_STDIV = 3'd3;
    localparam logic [2:0] PI_STRES = 3'd4;

    localparam logic [4:0] SLOT_DIV = 5'd20;

    typedef struct packed {
        logic       fetch;
        logic [3:0] ghi;
        logic [3:0] glo;
        logic [1:0] axis;
        logic [4:0] slot;
    } job_t;

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] a;
        logic [4:0] b;
    } prog_t;

    function automatic job_t mk_job(logic f, int hi, int lo, logic [1:0] ax, int sl);
        job_t j;
        j.fetch = f;
        j.ghi   = 4'(hi);
        j.glo   = 4'(lo);
        j.axis  = ax;
        j.slot  = 5'(sl);
        return j;
    endfunction

    // velocity center fetches, velocity gradients, density gradients, density center fetch, time derivatives
    function automatic job_t job_rom(logic [4:0] idx);
        job_t j;
        unique case (idx)
            5'd0:    j = mk_job(1'b1, 6, 6, AX_T, 0);
            5'd1:    j = mk_job(1'b1, 7, 7, AX_T, 1);
            5'd2:    j = mk_job(1'b1, 8, 8, AX_T, 2);
            5'd3:    j = mk_job(1'b0, 6, 6, AX_X, 3);
            5'd4:    j = mk_job(1'b0, 6, 6, AX_Y, 4);
            5'd5:    j = mk_job(1'b0, 6, 6, AX_Z, 5);
            5'd6:    j = mk_job(1'b0, 7, 7, AX_X, 6);
            5'd7:    j = mk_job(1'b0, 7, 7, AX_Y, 7);
            5'd8:    j = mk_job(1'b0, 7, 7, AX_Z, 8);
            5'd9:    j = mk_job(1'b0, 8, 8, AX_X, 9);
            5'd10:   j = mk_job(1'b0, 8, 8, AX_Y, 10);
            5'd11:   j = mk_job(1'b0, 8, 8, AX_Z, 11);
            5'd12:   j = mk_job(1'b0, 1, 1, AX_X, 12);
            5'd13:   j = mk_job(1'b0, 1, 1, AX_Y, 13);
            5'd14:   j = mk_job(1'b0, 1, 1, AX_Z, 14);
            5'd15:   j = mk_job(1'b1, 1, 1, AX_T, 15);
            5'd16:   j = mk_job(1'b0, 2, 0, AX_T, 16);
            5'd17:   j = mk_job(1'b0, 9, 3, AX_T, 17);
            5'd18:   j = mk_job(1'b0, 10, 4, AX_T, 18);
            5'd19:   j = mk_job(1'b0, 11, 5, AX_T, 19);
            default: j = mk_job(1'b1, 0, 0, AX_T, 0);
        endcase
        return j;
    endfunction

    function automatic prog_t mk_pi(logic [2:0] op, int a, int b);
        prog_t p;
        p.op = op;
        p.a  = 5'(a);
        p.b  = 5'(b);
        return p;
    endfunction

    // divergence, then density residual, then the three velocity residuals
    function automatic prog_t prog_rom(logic [4:0] idx);
        prog_t p;
        unique case (idx)
            5'd0:    p = mk_pi(PI_LOAD, 3, 0);
            5'd1:    p = mk_pi(PI_ADD, 7, 0);
            5'd2:    p = mk_pi(PI_ADD, 11, 0);
            5'd3:    p = mk_pi(PI_STDIV, 0, 0);
            5'd4:    p = mk_pi(PI_LOAD, 16, 0);
            5'd5:    p = mk_pi(PI_MAC, 0, 12);
            5'd6:    p = mk_pi(PI_MAC, 1, 13);
            5'd7:    p = mk_pi(PI_MAC, 2, 14);
            5'd8:    p = mk_pi(PI_MAC, 15, 20);
            5'd9:    p = mk_pi(PI_STRES, 0, 0);
            5'd10:   p = mk_pi(PI_LOAD, 17, 0);
            5'd11:   p = mk_pi(PI_MAC, 0, 3);
            5'd12:   p = mk_pi(PI_MAC, 1, 4);
            5'd13:   p = mk_pi(PI_MAC, 2, 5);
            5'd14:   p = mk_pi(PI_STRES, 1, 0);
            5'd15:   p = mk_pi(PI_LOAD, 18, 0);
            5'd16:   p = mk_pi(PI_MAC, 0, 6);
            5'd17:   p = mk_pi(PI_MAC, 1, 7);
            5'd18:   p = mk_pi(PI_MAC, 2, 8);
            5'd19:   p = mk_pi(PI_STRES, 2, 0);
            5'd20:   p = mk_pi(PI_LOAD, 19, 0);
            5'd21:   p = mk_pi(PI_MAC, 0, 9);
            5'd22:   p = mk_pi(PI_MAC, 1, 10);
            5'd23:   p = mk_pi(PI_MAC, 2, 11);
            5'd24:   p = mk_pi(PI_STRES, 3, 0);
            default: p = mk_pi(PI_STDIV, 0, 0);
        endcase
        return p;
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [CW-1:0] nb_plus(logic [CW-1:0] c, logic [CW-1:0] n,
                                              logic wrap);
        logic [CW-1:0] p;
        p = c + CW'(1);
        if (p >= n) return wrap ? '0 : n - CW'(1);
        return p;
    endfunction

    function automatic logic [CW-1:0] nb_minus(logic [CW-1:0] c, logic [CW-1:0] n,
                                               logic wrap);
        if (c == '0) return wrap ? n - CW'(1) : '0;
        return c - CW'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(logic [3:0] g, logic [CW-1:0] x,
                                                    logic [CW-1:0] y, logic [CW-1:0] z);
        return ADDR_W'(g) * ADDR_W'(GRID_CELLS) + ADDR_W'(z) * ADDR_W'(MAX_X * MAX_Y)
               + ADDR_W'(y) * ADDR_W'(MAX_X) + ADDR_W'(x);
    endfunction

    function automatic logic [CW-1:0] eff_size(logic [4:0] s, int mx);
        if (s == 5'd0) return CW'(1);
        if (CW'(s) > CW'(mx)) return CW'(mx);
        return CW'(s);
    endfunction

endpackage

// File: rtl/core/advection_residual_stencil_core.sv
// ----------------------------------------------------------------------------
// advection_residual_stencil_core
// Continuity and momentum residuals over stored 3D grids, with sum of squares.
// ----------------------------------------------------------------------------
// load, read and unused opcodes: result valid in the cycle after the beat
// compute: cell mapping, then 20 store jobs, 25 accumulate steps and 4 squares, sequenced
//   over the single store read port and one shared multiplier; result valid after the last square
// s_tready is low meanwhile and while a result beat waits on m_tready
// aresetn (synchronous) clears control, config and the sum-of-squares accumulators; store is not cleared
module advection_residual_stencil_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // pos_x, pos_y, pos_z, sample, zero pad
    input  logic [5:0]   s_tuser,   // opcode, grid_select
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [255:0] m_tdata,   // residual_density, residual_vx, residual_vy,
                                    // residual_vz, sum_sq_density, sum_sq_velocity
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int CW = adv_res_pkg::CW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CTR  = 3'd1;
    localparam logic [2:0] S_JOB  = 3'd2;
    localparam logic [2:0] S_PROG = 3'd3;
    localparam logic [2:0] S_SQ   = 3'd4;

    logic [2:0]  state_reg;
    logic [2:0]  ph_reg;
    logic [4:0]  job_idx_reg;
    logic [4:0]  prog_idx_reg;
    logic [1:0]  sq_idx_reg;

    logic [4:0]  size_x_reg, size_y_reg, size_z_reg;
    logic        wrap_reg;
    logic [31:0] inv_dt_reg, inv_hx_reg, inv_hy_reg, inv_hz_reg;

    logic [CW-1:0] cx_reg, cy_reg, cz_reg, nx_reg, ny_reg, nz_reg;

    logic signed [31:0]                   hi_reg;
    logic signed [32:0]                   mul_a_reg, mul_b_reg;
    logic signed [65:0]                   prod;
    logic signed [adv_res_pkg::ACC_W-1:0] acc_reg;
    logic signed [31:0]                   slot_reg [adv_res_pkg::NUM_SLOTS];
    logic signed [31:0]                   res_reg [4];
    logic [63:0]                          dens_acc_reg, vel_acc_reg;

    logic         m_tvalid_reg;
    logic [255:0] m_tdata_reg;

    logic                           mem_we;
    logic [adv_res_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [31:0]                    mem_rdata;

    logic               accept;
    logic [1:0]         in_op;
    logic [3:0]         in_gsel;
    logic [CW-1:0]      in_px, in_py, in_pz;
    adv_res_pkg::job_t  job;
    adv_res_pkg::prog_t pi;
    logic [CW-1:0]      hx, hy, hz, lx, ly, lz;
    logic [31:0]        inv_sel;
    logic signed [31:0] slot_rd;
    logic [4:0]         slot_ra;
    logic [64:0]        sq_sum;
    logic [63:0]        sq_sat;
    logic [63:0]        sq_base;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE) && !m_tvalid_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign in_op   = s_tuser[1:0];
    assign in_gsel = s_tuser[5:2];
    assign in_px   = CW'(s_tdata[3:0]);
    assign in_py   = CW'(s_tdata[7:4]);
    assign in_pz   = CW'(s_tdata[11:8]);

    assign job = adv_res_pkg::job_rom(job_idx_reg);
    assign pi  = adv_res_pkg::prog_rom(prog_idx_reg);

    // load beat writes the store directly
    assign mem_we = accept && (in_op == adv_res_pkg::OP_LOAD)
                    && (in_gsel < 4'(adv_res_pkg::NUM_GRIDS))
                    && (in_px < CW'(adv_res_pkg::MAX_X))
                    && (in_py < CW'(adv_res_pkg::MAX_Y))
                    && (in_pz < CW'(adv_res_pkg::MAX_Z));
    assign mem_waddr = adv_res_pkg::cell_addr(in_gsel, in_px, in_py, in_pz);

    // neighbor coordinates for the current job
    always_comb begin
        hx = cx_reg; hy = cy_reg; hz = cz_reg;
        lx = cx_reg; ly = cy_reg; lz = cz_reg;
        inv_sel = inv_dt_reg;
        if (!job.fetch) begin
            unique case (job.axis)
                adv_res_pkg::AX_X: begin
                    hx = adv_res_pkg::nb_plus(cx_reg, nx_reg, wrap_reg);
                    lx = adv_res_pkg::nb_minus(cx_reg, nx_reg, wrap_reg);
                    inv_sel = inv_hx_reg;
                end
                adv_res_pkg::AX_Y: begin
                    hy = adv_res_pkg::nb_plus(cy_reg, ny_reg, wrap_reg);
                    ly = adv_res_pkg::nb_minus(cy_reg, ny_reg, wrap_reg);
                    inv_sel = inv_hy_reg;
                end
                adv_res_pkg::AX_Z: begin
                    hz = adv_res_pkg::nb_plus(cz_reg, nz_reg, wrap_reg);
                    lz = adv_res_pkg::nb_minus(cz_reg, nz_reg, wrap_reg);
                    inv_sel = inv_hz_reg;
                end
                default: inv_sel = inv_dt_reg;
            endcase
        end
    end

    assign mem_raddr = (ph_reg == 3'd0) ? adv_res_pkg::cell_addr(job.ghi, hx, hy, hz)
                                        : adv_res_pkg::cell_addr(job.glo, lx, ly, lz);

    assign slot_ra = (ph_reg == 3'd1) ? pi.b : pi.a;
    assign slot_rd = slot_reg[slot_ra];

    assign sq_base = (sq_idx_reg == 2'd0) ? dens_acc_reg : vel_acc_reg;
    assign sq_sum  = {1'b0, sq_base} + {1'b0, prod[63:0]};
    assign sq_sat  = sq_sum[64] ? '1 : sq_sum[63:0];

    adv_res_store u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (s_tdata[43:12]),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    adv_res_mul u_mul (
        .aclk     (aclk),
        .op_a     (mul_a_reg),
        .op_b     (mul_b_reg),
        .prod_reg (prod)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= 5'd16;
            size_y_reg <= 5'd16;
            size_z_reg <= 5'd16;
            wrap_reg   <= 1'b0;
            inv_dt_reg <= 32'd32768;
            inv_hx_reg <= 32'd32768;
            inv_hy_reg <= 32'd32768;
            inv_hz_reg <= 32'd32768;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                adv_res_pkg::REG_SIZE_X: size_x_reg <= cfg_data[4:0];
                adv_res_pkg::REG_SIZE_Y: size_y_reg <= cfg_data[4:0];
                adv_res_pkg::REG_SIZE_Z: size_z_reg <= cfg_data[4:0];
                adv_res_pkg::REG_WRAP:   wrap_reg   <= cfg_data[0];
                adv_res_pkg::REG_INV_DT: inv_dt_reg <= cfg_data;
                adv_res_pkg::REG_INV_HX: inv_hx_reg <= cfg_data;
                adv_res_pkg::REG_INV_HY: inv_hy_reg <= cfg_data;
                adv_res_pkg::REG_INV_HZ: inv_hz_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // datapath registers without reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            cx_reg <= in_px;
            cy_reg <= in_py;
            cz_reg <= in_pz;
            nx_reg <= adv_res_pkg::eff_size(size_x_reg, adv_res_pkg::MAX_X);
            ny_reg <= adv_res_pkg::eff_size(size_y_reg, adv_res_pkg::MAX_Y);
            nz_reg <= adv_res_pkg::eff_size(size_z_reg, adv_res_pkg::MAX_Z);
            m_tdata_reg <= {vel_acc_reg, dens_acc_reg, 128'd0};
        end
        if (state_reg == S_CTR) begin
            // wrap reduces by repeated subtraction, clamp goes to the edge at once
            if (cx_reg >= nx_reg) cx_reg <= wrap_reg ? cx_reg - nx_reg : nx_reg - CW'(1);
            if (cy_reg >= ny_reg) cy_reg <= wrap_reg ? cy_reg - ny_reg : ny_reg - CW'(1);
            if (cz_reg >= nz_reg) cz_reg <= wrap_reg ? cz_reg - nz_reg : nz_reg - CW'(1);
        end
        if (state_reg == S_JOB) begin
            if (ph_reg == 3'd1) begin
                hi_reg <= $signed(mem_rdata);
                if (job.fetch) slot_reg[job.slot] <= $signed(mem_rdata);
            end
            if (ph_reg == 3'd2) begin
                mul_a_reg <= 33'(hi_reg) - 33'($signed(mem_rdata));
                mul_b_reg <= $signed({1'b0, inv_sel});
            end
            if (ph_reg == 3'd4) slot_reg[job.slot] <= adv_res_pkg::sat32(prod >>> 16);
        end
        if (state_reg == S_PROG) begin
            unique case (pi.op)
                adv_res_pkg::PI_LOAD:  acc_reg <= adv_res_pkg::ACC_W'(slot_rd);
                adv_res_pkg::PI_ADD:   acc_reg <= acc_reg + adv_res_pkg::ACC_W'(slot_rd);
                adv_res_pkg::PI_STDIV: slot_reg[adv_res_pkg::SLOT_DIV]
                                           <= adv_res_pkg::sat32(66'(acc_reg));
                adv_res_pkg::PI_STRES: res_reg[pi.a[1:0]]
                                           <= adv_res_pkg::sat32(66'(acc_reg));
                adv_res_pkg::PI_MAC: begin
                    if (ph_reg == 3'd0) mul_a_reg <= 33'(slot_rd);
                    if (ph_reg == 3'd1) mul_b_reg <= 33'(slot_rd);
                    if (ph_reg == 3'd3)
                        acc_reg <= acc_reg + adv_res_pkg::ACC_W'(prod >>> 16);
                end
                default: ;
            endcase
        end
        if (state_reg == S_SQ && ph_reg == 3'd0) begin
            mul_a_reg <= 33'(res_reg[sq_idx_reg]);
            mul_b_reg <= 33'(res_reg[sq_idx_reg]);
        end
        if (state_reg == S_SQ && ph_reg == 3'd2 && sq_idx_reg == 2'd3) begin
            m_tdata_reg <= {sq_sat, dens_acc_reg, res_reg[3], res_reg[2],
                            res_reg[1], res_reg[0]};
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ph_reg       <= 3'd0;
            job_idx_reg  <= 5'd0;
            prog_idx_reg <= 5'd0;
            sq_idx_reg   <= 2'd0;
            m_tvalid_reg <= 1'b0;
            dens_acc_reg <= 64'd0;
            vel_acc_reg  <= 64'd0;
        end else begin
            if (m_tvalid_reg && m_tready) m_tvalid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if (in_op == adv_res_pkg::OP_COMPUTE) begin
                            state_reg <= S_CTR;
                        end else begin
                            m_tvalid_reg <= 1'b1;
                            if (in_op == adv_res_pkg::OP_READ) begin
                                dens_acc_reg <= 64'd0;
                                vel_acc_reg  <= 64'd0;
                            end
                        end
                    end
                end
                S_CTR: begin
                    if (cx_reg < nx_reg && cy_reg < ny_reg && cz_reg < nz_reg) begin
                        state_reg   <= S_JOB;
                        job_idx_reg <= 5'd0;
                        ph_reg      <= 3'd0;
                    end
                end
                S_JOB: begin
                    if ((ph_reg == 3'd1 && job.fetch) || ph_reg == 3'd4) begin
                        ph_reg <= 3'd0;
                        if (job_idx_reg == 5'(adv_res_pkg::NUM_JOBS - 1)) begin
                            state_reg    <= S_PROG;
                            prog_idx_reg <= 5'd0;
                        end else begin
                            job_idx_reg <= job_idx_reg + 5'd1;
                        end
                    end else begin
                        ph_reg <= ph_reg + 3'd1;
                    end
                end
                S_PROG: begin
                    if (pi.op != adv_res_pkg::PI_MAC || ph_reg == 3'd3) begin
                        ph_reg <= 3'd0;
                        if (prog_idx_reg == 5'(adv_res_pkg::NUM_PROG - 1)) begin
                            state_reg  <= S_SQ;
                            sq_idx_reg <= 2'd0;
                        end else begin
                            prog_idx_reg <= prog_idx_reg + 5'd1;
                        end
                    end else begin
                        ph_reg <= ph_reg + 3'd1;
                    end
                end
                S_SQ: begin
                    if (ph_reg == 3'd2) begin
                        ph_reg <= 3'd0;
                        if (sq_idx_reg == 2'd0) dens_acc_reg <= sq_sat;
                        else                    vel_acc_reg  <= sq_sat;
                        if (sq_idx_reg == 2'd3) begin
                            state_reg    <= S_IDLE;
                            m_tvalid_reg <= 1'b1;
                        end else begin
                            sq_idx_reg <= sq_idx_reg + 2'd1;
                        end
                    end else begin
                        ph_reg <= ph_reg + 3'd1;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_busy_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !m_tvalid_reg)
        else $error("result beat pending during compute");

    a_compute_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_op == adv_res_pkg::OP_COMPUTE) |=> (state_reg == S_CTR))
        else $error("compute beat did not start sequencer");

    a_read_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_op == adv_res_pkg::OP_READ) |=>
        (dens_acc_reg == 64'd0 && vel_acc_reg == 64'd0 && m_tvalid_reg))
        else $error("read beat did not clear sums");

    a_job_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_JOB) |-> (job_idx_reg < 5'(adv_res_pkg::NUM_JOBS)))
        else $error("job index out of range");

endmodule

// File: rtl/core/adv_res_store.sv
// ----------------------------------------------------------------------------
// adv_res_store
// Sample store for the twelve grids: one write port, one registered read port.
// ----------------------------------------------------------------------------
module adv_res_store (
    input  logic                            aclk,
    input  logic                            we,
    input  logic [adv_res_pkg::ADDR_W-1:0]  waddr,
    input  logic [31:0]                     wdata,
    input  logic [adv_res_pkg::ADDR_W-1:0]  raddr,
    output logic [31:0]                     rdata
);

    logic [31:0] mem [adv_res_pkg::DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/adv_res_mul.sv
// ----------------------------------------------------------------------------
// adv_res_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module adv_res_mul (
    input  logic               aclk,
    input  logic signed [32:0] op_a,
    input  logic signed [32:0] op_b,
    output logic signed [65:0] prod_reg
);

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

endmodule

// File: verif/tb_advection_residual_stencil_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_advection_residual_stencil_core
// Loads small grids, computes cell residuals and reads the sums of squares,
// checking every result beat against a predictor of the core.
// ----------------------------------------------------------------------------
module tb_advection_residual_stencil_core;

    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  grid_sel;
        logic [3:0]  px;
        logic [3:0]  py;
        logic [3:0]  pz;
        logic [31:0] sample;
    } cmd_t;

    typedef struct packed {
        logic [31:0] r_den;
        logic [31:0] r_vx;
        logic [31:0] r_vy;
        logic [31:0] r_vz;
        logic [63:0] ss_den;
        logic [63:0] ss_vel;
    } resid_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [47:0]  s_tdata = '0;
    logic [5:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [255:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    advection_residual_stencil_core i_dut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // predictor state
    logic [31:0] grid_mem [0:adv_res_pkg::DEPTH-1];
    logic [63:0] acc_den, acc_vel;
    logic [4:0]  sz_x, sz_y, sz_z;
    logic        wrap_on;
    logic [31:0] inv_dt, inv_hx, inv_hy, inv_hz;

    cmd_t   pending_cmds[$];
    resid_t expected_resid[$];
    int     src_idle_pct = 0, snk_idle_pct = 0;
    int     hold_cycles = 0;
    bit     failed = 0;
    int     quiet_cycles = 0;
    int     in_beats = 0;
    int     offered = 0;

    function automatic longint sat_q16(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint floor_q16(longint v);
        return v >>> 16;
    endfunction

    function automatic longint slope(longint diff, logic [31:0] inv);
        logic signed [97:0] p;
        p = 98'(diff) * $signed({66'd0, inv});
        p = p >>> 16;
        if (p > 98'sd2147483647) return 64'sd2147483647;
        if (p < -98'sd2147483648) return -64'sd2147483648;
        return longint'(p);
    endfunction

    function automatic int cells(logic [4:0] s);
        if (s == 0) return 1;
        return s > 16 ? 16 : int'(s);
    endfunction

    function automatic int nbr(int v, int n);
        if (v < 0) return wrap_on ? n - 1 : 0;
        if (v >= n) return wrap_on ? 0 : n - 1;
        return v;
    endfunction

    function automatic longint peek(int g, int x, int y, int z);
        return longint'($signed(grid_mem[g * adv_res_pkg::GRID_CELLS
                                         + (z * adv_res_pkg::MAX_Y + y) * adv_res_pkg::MAX_X
                                         + x]));
    endfunction

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic resid_t predict_residual(cmd_t c);
        resid_t r;
        int nx, ny, nz, x, y, z, k, a;
        longint u[3], g[3][3], ds[3], dv, s, rr[4];
        r = '0;
        if (c.opcode == adv_res_pkg::OP_LOAD) begin
            if (c.grid_sel < adv_res_pkg::NUM_GRIDS) begin
                k = c.grid_sel * adv_res_pkg::GRID_CELLS
                    + (c.pz * adv_res_pkg::MAX_Y + c.py) * adv_res_pkg::MAX_X + c.px;
                grid_mem[k] = c.sample;
            end
        end else if (c.opcode == adv_res_pkg::OP_COMPUTE) begin
            nx = cells(sz_x); ny = cells(sz_y); nz = cells(sz_z);
            x = wrap_on ? c.px % nx : (c.px >= nx ? nx - 1 : c.px);
            y = wrap_on ? c.py % ny : (c.py >= ny ? ny - 1 : c.py);
            z = wrap_on ? c.pz % nz : (c.pz >= nz ? nz - 1 : c.pz);
            for (k = 0; k < 3; k++) begin
                u[k] = peek(6 + k, x, y, z);
                g[k][0] = slope(peek(6+k, nbr(x+1,nx), y, z) - peek(6+k, nbr(x-1,nx), y, z),
                                inv_hx);
                g[k][1] = slope(peek(6+k, x, nbr(y+1,ny), z) - peek(6+k, x, nbr(y-1,ny), z),
                                inv_hy);
                g[k][2] = slope(peek(6+k, x, y, nbr(z+1,nz)) - peek(6+k, x, y, nbr(z-1,nz)),
                                inv_hz);
            end
            ds[0] = slope(peek(1, nbr(x+1,nx), y, z) - peek(1, nbr(x-1,nx), y, z), inv_hx);
            ds[1] = slope(peek(1, x, nbr(y+1,ny), z) - peek(1, x, nbr(y-1,ny), z), inv_hy);
            ds[2] = slope(peek(1, x, y, nbr(z+1,nz)) - peek(1, x, y, nbr(z-1,nz)), inv_hz);
            dv = sat_q16(g[0][0] + g[1][1] + g[2][2]);
            s = slope(peek(2, x, y, z) - peek(0, x, y, z), inv_dt)
                + floor_q16(peek(1, x, y, z) * dv);
            for (a = 0; a < 3; a++) s += floor_q16(u[a] * ds[a]);
            rr[0] = sat_q16(s);
            for (k = 0; k < 3; k++) begin
                s = slope(peek(9 + k, x, y, z) - peek(3 + k, x, y, z), inv_dt);
                for (a = 0; a < 3; a++) s += floor_q16(u[a] * g[k][a]);
                rr[1 + k] = sat_q16(s);
            end
            acc_den = add_sat(acc_den, 64'(rr[0] * rr[0]));
            for (k = 1; k < 4; k++) acc_vel = add_sat(acc_vel, 64'(rr[k] * rr[k]));
            r.r_den = rr[0][31:0]; r.r_vx = rr[1][31:0];
            r.r_vy = rr[2][31:0]; r.r_vz = rr[3][31:0];
        end
        r.ss_den = acc_den;
        r.ss_vel = acc_vel;
        if (c.opcode == adv_res_pkg::OP_READ) begin
            acc_den = '0;
            acc_vel = '0;
        end
        return r;
    endfunction

    // input beats taken so far
    always @(posedge aclk) begin
        if (s_tvalid && s_tready) in_beats <= in_beats + 1;
    end

    // driver: a new beat goes out once the offered one has been taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_beats == offered) begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                cmd_t c;
                c = pending_cmds.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= {c.grid_sel, c.opcode};
                s_tdata  <= {4'd0, c.sample, c.pz, c.py, c.px};
                offered  <= offered + 1;
                expected_resid.push_back(predict_residual(c));
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            resid_t got, want;
            got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96],
                   m_tdata[191:128], m_tdata[255:192]};
            if (expected_resid.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, m_tdata);
                failed = 1;
            end else begin
                want = expected_resid.pop_front();
                if (got.r_den !== want.r_den)
                    $display("%0t: residual_density exp %h got %h", $time, want.r_den,
                             got.r_den);
                if (got.r_vx !== want.r_vx)
                    $display("%0t: residual_vx exp %h got %h", $time, want.r_vx, got.r_vx);
                if (got.r_vy !== want.r_vy)
                    $display("%0t: residual_vy exp %h got %h", $time, want.r_vy, got.r_vy);
                if (got.r_vz !== want.r_vz)
                    $display("%0t: residual_vz exp %h got %h", $time, want.r_vz, got.r_vz);
                if (got.ss_den !== want.ss_den)
                    $display("%0t: sum_sq_density exp %h got %h", $time, want.ss_den,
                             got.ss_den);
                if (got.ss_vel !== want.ss_vel)
                    $display("%0t: sum_sq_velocity exp %h got %h", $time, want.ss_vel,
                             got.ss_vel);
                if (got !== want) failed = 1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || !aresetn || hold_cycles > 0)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("tb_advection_residual_stencil_core NOT OK");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            adv_res_pkg::REG_SIZE_X: sz_x = val[4:0];
            adv_res_pkg::REG_SIZE_Y: sz_y = val[4:0];
            adv_res_pkg::REG_SIZE_Z: sz_z = val[4:0];
            adv_res_pkg::REG_WRAP:   wrap_on = val[0];
            adv_res_pkg::REG_INV_DT: inv_dt = val;
            adv_res_pkg::REG_INV_HX: inv_hx = val;
            adv_res_pkg::REG_INV_HY: inv_hy = val;
            default:                 inv_hz = val;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || expected_resid.size() > 0 || s_tvalid)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(16'hffff)) - 32768) <<< 4;
        endcase
    endfunction

    function automatic cmd_t mk_cmd(logic [1:0] op, logic [3:0] g, int x, int y, int z,
                                    logic [31:0] smp);
        cmd_t c;
        c.opcode = op; c.grid_sel = g;
        c.px = 4'(x); c.py = 4'(y); c.pz = 4'(z); c.sample = smp;
        return c;
    endfunction

    // fill all twelve grids over the box in use so computes never see unwritten cells
    task automatic load_box(int nx, int ny, int nz, bit extremes);
        for (int g = 0; g < adv_res_pkg::NUM_GRIDS; g++)
            for (int z = 0; z < nz; z++)
                for (int y = 0; y < ny; y++)
                    for (int x = 0; x < nx; x++)
                        pending_cmds.push_back(mk_cmd(adv_res_pkg::OP_LOAD, 4'(g), x, y, z,
                            extremes ? ((x + y + z + g) % 2 ? 32'h7fffffff : 32'h80000000)
                                     : rand_sample()));
    endtask

    // fill all twelve grids over the cells x0..x1-1, y0..y1-1, z0..z1-1
    task automatic load_slab(int x0, int x1, int y0, int y1, int z0, int z1);
        for (int g = 0; g < adv_res_pkg::NUM_GRIDS; g++)
            for (int z = z0; z < z1; z++)
                for (int y = y0; y < y1; y++)
                    for (int x = x0; x < x1; x++)
                        pending_cmds.push_back(mk_cmd(adv_res_pkg::OP_LOAD, 4'(g), x, y, z,
                                                      rand_sample()));
    endtask

    task automatic run_phase(int nx, int ny, int nz, bit wrap, logic [31:0] dt,
                             logic [31:0] hx, logic [31:0] hy, logic [31:0] hz, int n);
        int k;
        write_reg(adv_res_pkg::REG_SIZE_X, 32'(nx));
        write_reg(adv_res_pkg::REG_SIZE_Y, 32'(ny));
        write_reg(adv_res_pkg::REG_SIZE_Z, 32'(nz));
        write_reg(adv_res_pkg::REG_WRAP, 32'(wrap));
        write_reg(adv_res_pkg::REG_INV_DT, dt);
        write_reg(adv_res_pkg::REG_INV_HX, hx);
        write_reg(adv_res_pkg::REG_INV_HY, hy);
        write_reg(adv_res_pkg::REG_INV_HZ, hz);
        for (k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0, 1: begin
                    // reload a cell inside the box, or an ignored load
                    if ($urandom_range(7) == 0)
                        pending_cmds.push_back(mk_cmd(adv_res_pkg::OP_LOAD,
                            4'($urandom_range(15, 12)),
                            $urandom_range(15), $urandom_range(15), $urandom_range(15),
                            rand_sample()));
                    else
                        pending_cmds.push_back(mk_cmd(adv_res_pkg::OP_LOAD,
                            4'($urandom_range(11)),
                            $urandom_range(nx - 1), $urandom_range(ny - 1),
                            $urandom_range(nz - 1), rand_sample()));
                end
                2: pending_cmds.push_back(mk_cmd(adv_res_pkg::OP_READ, 4'($urandom),
                                                 $urandom, $urandom, $urandom, $urandom));
                3: pending_cmds.push_back(mk_cmd(OP_SPARE, 4'($urandom), $urandom, $urandom,
                                                 $urandom, $urandom));
                default: pending_cmds.push_back(mk_cmd(adv_res_pkg::OP_COMPUTE, 4'($urandom),
                    $urandom_range(15), $urandom_range(15), $urandom_range(15), $urandom));
            endcase
        end
        drain();
    endtask

    initial begin
        acc_den = '0; acc_vel = '0;
        sz_x = 16; sz_y = 16; sz_z = 16; wrap_on = 0;
        inv_dt = 32768; inv_hx = 32768; inv_hy = 32768; inv_hz = 32768;
        foreach (grid_mem[i]) grid_mem[i] = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extreme samples on a 2x2x2 box, saturating derivatives and sums
        src_idle_pct = 32; snk_idle_pct = 80;
        load_box(2, 2, 2, 1);
        drain();
        write_reg(adv_res_pkg::REG_SIZE_X, 32'd2); write_reg(adv_res_pkg::REG_SIZE_Y, 32'd2);
        write_reg(adv_res_pkg::REG_SIZE_Z, 32'd2);
        write_reg(adv_res_pkg::REG_INV_DT, 32'hffffffff);
        write_reg(adv_res_pkg::REG_INV_HX, 32'hffffffff);
        write_reg(adv_res_pkg::REG_INV_HY, 32'hffffffff);
        write_reg(adv_res_pkg::REG_INV_HZ, 32'hffffffff);
        pending_cmds.push_back(mk_cmd(adv_res_pkg::OP_COMPUTE, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(adv_res_pkg::OP_COMPUTE, 0, 15, 15, 15, 0));
        pending_cmds.push_back(mk_cmd(adv_res_pkg::OP_COMPUTE, 0, 1, 0, 1, 0));
        pending_cmds.push_back(mk_cmd(adv_res_pkg::OP_READ, 0, 0, 0, 0, 0));
        pending_cmds.push_back(mk_cmd(adv_res_pkg::OP_LOAD, 4'd15, 15, 15, 15, 32'hffffffff));
        pending_cmds.push_back(mk_cmd(OP_SPARE, 4'd15, 15, 15, 15, 32'hffffffff));
        pending_cmds.push_back(mk_cmd(adv_res_pkg::OP_READ, 4'd15, 15, 15, 15, 32'hffffffff));
        drain();
        write_reg(adv_res_pkg::REG_WRAP, 32'd1);
        pending_cmds.push_back(mk_cmd(adv_res_pkg::OP_COMPUTE, 0, 3, 2, 15, 0));
        pending_cmds.push_back(mk_cmd(adv_res_pkg::OP_READ, 0, 0, 0, 0, 0));
        drain();
        // size zero acts as one; a size of 31 clamps to 16, so the wrapped y
        // neighbors of rows 0 and 15 are loaded
        write_reg(adv_res_pkg::REG_SIZE_X, 32'd0); write_reg(adv_res_pkg::REG_SIZE_Y, 32'd31);
        write_reg(adv_res_pkg::REG_SIZE_Z, 32'd1);
        load_slab(0, 1, 0, 2, 0, 1);
        load_slab(0, 1, 14, 16, 0, 1);
        pending_cmds.push_back(mk_cmd(adv_res_pkg::OP_COMPUTE, 0, 9, 15, 7, 0));
        pending_cmds.push_back(mk_cmd(adv_res_pkg::OP_COMPUTE, 0, 0, 0, 0, 0));
        drain();

        // random phases on small boxes
        load_box(3, 3, 2, 0);
        drain();
        run_phase(3, 3, 2, 0, 32768, 32768, 65536, 4096, 50);
        run_phase(3, 3, 2, 1, $urandom, $urandom, $urandom, $urandom, 50);

        // sink stalls for a long stretch while sources keep offering
        hold_cycles = 600;
        src_idle_pct = 0;
        run_phase(3, 3, 2, 1, 0, 0, 0, 0, 40);

        src_idle_pct = 80; snk_idle_pct = 32;
        load_slab(3, 4, 0, 2, 0, 2);
        drain();
        run_phase(4, 2, 2, 0, 32'hffffffff, 1, 32'h10000, 32'h7fffffff, 40);
        run_phase(4, 2, 2, 1, 32'h100, 32'h100, 32'h100, 32'h100, 40);

        src_idle_pct = 0; snk_idle_pct = 0;
        load_slab(0, 2, 3, 4, 0, 2);
        drain();
        run_phase(2, 4, 2, 1, $urandom, $urandom, $urandom, $urandom, 40);
        run_phase(1, 1, 1, 0, 32768, 32768, 32768, 32768, 30);

        if (!failed && expected_resid.size() == 0)
            $display("tb_advection_residual_stencil_core OK");
        else
            $display("tb_advection_residual_stencil_core NOT OK");
        $finish;
    end
endmodule

// File: sim.f
rtl/core/adv_res_pkg.sv
rtl/core/adv_res_store.sv
rtl/core/adv_res_mul.sv
rtl/core/advection_residual_stencil_core.sv
verif/tb_advection_residual_stencil_core.sv
